/* design/ans_pkg.sv */
// Package for the Annex B NAL splitter: transaction types, codec and NAL type codes,
// and the header flag decode shared by the scanner.
// No dependencies.
`default_nettype none

package ans_pkg;

   // Default largest buffer in bytes; positions saturate here.
   localparam int ANS_DEF_MAX_BUFFER_BYTES = 65536;

   // Configuration port geometry.
   localparam int ANS_ADDR_W = 3;
   localparam int ANS_DATA_W = 32;
   localparam logic ANS_REG_CODEC_MODE = 1'b0;  // word index of codec_mode

   // Field widths of the result transaction.
   localparam int ANS_OFFSET_W = 16;
   localparam int ANS_LENGTH_W = 17;

   // Codec selections (the fourth code means no codec).
   localparam logic [1:0] ANS_CODEC_NONE = 2'd0;
   localparam logic [1:0] ANS_CODEC_H264 = 2'd1;
   localparam logic [1:0] ANS_CODEC_H265 = 2'd2;

   // H.264 NAL unit types.
   localparam logic [4:0] ANS_AVC_IDR = 5'd5;
   localparam logic [4:0] ANS_AVC_SPS = 5'd7;
   localparam logic [4:0] ANS_AVC_PPS = 5'd8;

   // H.265 NAL unit types.
   localparam logic [5:0] ANS_HEVC_IDR_RADL = 6'd19;
   localparam logic [5:0] ANS_HEVC_IDR_NLP  = 6'd20;
   localparam logic [5:0] ANS_HEVC_VPS      = 6'd32;
   localparam logic [5:0] ANS_HEVC_SPS      = 6'd33;
   localparam logic [5:0] ANS_HEVC_PPS      = 6'd34;

   // One input transaction: a buffer byte with its end mark and timestamp.
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        buffer_end;
      logic [63:0] time_stamp;
   } ans_req_type;

   // One result transaction: a NAL unit descriptor.
   typedef struct packed {
      logic [ANS_OFFSET_W-1:0] nal_offset;
      logic [ANS_LENGTH_W-1:0] nal_length;
      logic                    idr_flag;
      logic                    vps_flag;
      logic                    sps_flag;
      logic                    pps_flag;
      logic                    final_of_buffer;
      logic [63:0]             stamp_out;
      logic                    overflow;
   } ans_rsp_type;

   // Header flags decoded from the first header byte.
   typedef struct packed {
      logic idr;
      logic vps;
      logic sps;
      logic pps;
   } ans_flags_type;

   // Decode the parameter set and IDR flags for the selected codec.
   function automatic ans_flags_type ans_decode_flags(input logic [1:0] codec,
                                                      input logic [7:0] hdr,
                                                      input logic       len_ge2);
      ans_flags_type f;
      logic [4:0]    avc_type;
      logic [5:0]    hevc_type;
      f         = '0;
      avc_type  = hdr[4:0];
      hevc_type = hdr[6:1];
      if (codec == ANS_CODEC_H264) begin
         f.idr = (avc_type == ANS_AVC_IDR);
         f.sps = (avc_type == ANS_AVC_SPS);
         f.pps = (avc_type == ANS_AVC_PPS);
      end else if (codec == ANS_CODEC_H265 && len_ge2) begin
         f.idr = (hevc_type == ANS_HEVC_IDR_RADL) || (hevc_type == ANS_HEVC_IDR_NLP);
         f.vps = (hevc_type == ANS_HEVC_VPS);
         f.sps = (hevc_type == ANS_HEVC_SPS);
         f.pps = (hevc_type == ANS_HEVC_PPS);
      end
      return f;
   endfunction

endpackage : ans_pkg

`default_nettype wire

/* design/ans_csr.sv */
// Configuration register block of the Annex B NAL splitter: holds codec_mode.
// Depends on ans_pkg.
`default_nettype none

module ans_csr
   import ans_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [ANS_ADDR_W-1:0] csr_paddr,
   input  wire logic [ANS_DATA_W-1:0] csr_pwdata,
   output logic      [ANS_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output logic      [1:0]            codec_mode
);

   logic [1:0] codec_ff;
   logic [1:0] codec_in;
   logic       wr_en;
   logic       reg_hit;

   // A write completes in the access phase; the port never waits.
   assign csr_pready = 1'b1;
   assign reg_hit    = (csr_paddr[2] == ANS_REG_CODEC_MODE);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready && reg_hit;

   // Next value of the codec register.
   always_comb begin
      codec_in = codec_ff;
      if (wr_en) begin
         codec_in = csr_pwdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codec_ff <= ANS_CODEC_NONE;
      end else begin
         codec_ff <= codec_in;
      end
   end

   // Reads return the register, zero elsewhere.
   always_comb begin
      csr_prdata = '0;
      if (reg_hit) begin
         csr_prdata = {{(ANS_DATA_W-2){1'b0}}, codec_ff};
      end
   end

   assign codec_mode = codec_ff;

endmodule : ans_csr

`default_nettype wire

/* design/ans_scan.sv */
// Start code scanner of the Annex B NAL splitter: per-buffer state and the
// combinational descriptor computation for one byte. Depends on ans_pkg.
`default_nettype none

module ans_scan
   import ans_pkg::*;
#(
   parameter int MAX_BUFFER_BYTES = ANS_DEF_MAX_BUFFER_BYTES
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        fire,
   input  wire ans_req_type item,
   input  wire logic [1:0]  codec_mode,
   output logic             emit,
   output ans_rsp_type      desc
);

   localparam int PW = $clog2(MAX_BUFFER_BYTES + 1);
   localparam logic [PW-1:0] MaxPos = PW'(MAX_BUFFER_BYTES);

   // Per-buffer state.
   logic [PW-1:0] pos_ff,   pos_in;
   logic [2:0]    zh_ff,    zh_in;
   logic [PW-1:0] begin_ff, begin_in;
   logic          start_ff, start_in;
   logic [7:0]    hdr_ff,   hdr_in;
   logic          ovf_ff,   ovf_in;

   // Working values for the current byte.
   logic          sat;
   logic          ovf_now;
   logic [PW-1:0] next_pos;
   logic [7:0]    hdr_now;
   logic          is_sc;
   logic [PW:0]   idx_p1;
   logic [PW:0]   sc_len;
   logic [PW-1:0] sc_start;
   logic [PW-1:0] begin_t;
   logic          emit_sc;
   logic          emit_tail;
   logic [PW-1:0] nal_len;
   ans_flags_type flags;

   // Position, saturation and start code detection.
   always_comb begin
      sat      = (pos_ff >= MaxPos);
      ovf_now  = ovf_ff || sat;
      next_pos = sat ? MaxPos : pos_ff + 1'b1;
      hdr_now  = (pos_ff == begin_ff) ? item.data_byte : hdr_ff;
      is_sc    = (item.data_byte == 8'd1) && (zh_ff[1:0] == 2'b11);
      idx_p1   = {1'b0, pos_ff} + 1'b1;
      sc_len   = zh_ff[2] ? (PW+1)'(4) : (PW+1)'(3);
      sc_start = (idx_p1 >= sc_len) ? PW'(idx_p1 - sc_len) : '0;
      begin_t  = start_ff ? begin_ff : '0;
   end

   // Descriptor for the unit closed by a start code or by the buffer end.
   always_comb begin
      emit_sc   = is_sc && start_ff && (sc_start > begin_ff);
      emit_tail = !is_sc && item.buffer_end && (next_pos > begin_t);
      nal_len   = is_sc ? sc_start - begin_ff : next_pos - begin_t;
      emit      = emit_sc || emit_tail;
      flags     = ans_decode_flags(codec_mode, hdr_now, (nal_len >= PW'(2)));

      desc                 = '0;
      desc.nal_offset      = ANS_OFFSET_W'(begin_t);
      desc.nal_length      = ANS_LENGTH_W'(nal_len);
      desc.idr_flag        = flags.idr;
      desc.vps_flag        = flags.vps;
      desc.sps_flag        = flags.sps;
      desc.pps_flag        = flags.pps;
      desc.final_of_buffer = item.buffer_end;
      desc.stamp_out       = item.time_stamp;
      desc.overflow        = ovf_now;
   end

   // State update for an accepted byte; a buffer end clears everything.
   always_comb begin
      pos_in   = pos_ff;
      zh_in    = zh_ff;
      begin_in = begin_ff;
      start_in = start_ff;
      hdr_in   = hdr_ff;
      ovf_in   = ovf_ff;
      if (fire) begin
         pos_in = next_pos;
         zh_in  = {zh_ff[1:0], (item.data_byte == 8'd0)};
         ovf_in = ovf_now;
         hdr_in = hdr_now;
         if (is_sc) begin
            begin_in = next_pos;
            start_in = 1'b1;
            hdr_in   = '0;
         end
         if (item.buffer_end) begin
            pos_in   = '0;
            zh_in    = '0;
            begin_in = '0;
            start_in = 1'b0;
            hdr_in   = '0;
            ovf_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         zh_ff    <= '0;
         begin_ff <= '0;
         start_ff <= 1'b0;
         hdr_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         zh_ff    <= zh_in;
         begin_ff <= begin_in;
         start_ff <= start_in;
         hdr_ff   <= hdr_in;
         ovf_ff   <= ovf_in;
      end
   end

   // The byte position never passes the saturation point.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= MaxPos)
      else $error("byte position beyond buffer limit");

   // A unit never starts after the current position.
   a_begin_le_pos: assert property (@(posedge clock) disable iff (reset)
      begin_ff <= pos_ff)
      else $error("unit start beyond byte position");

   // A descriptor never has zero length.
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      fire && emit |-> nal_len != '0)
      else $error("empty unit emitted");

   // The buffer end leaves the scanner at its initial state.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      fire && item.buffer_end |=> pos_ff == '0 && !start_ff && !ovf_ff && zh_ff == '0)
      else $error("buffer state not cleared at buffer end");

endmodule : ans_scan

`default_nettype wire

/* design/annexb_nal_splitter.sv */
// Top level of the Annex B NAL splitter: input register, scanner, result register
// and configuration port. Depends on ans_pkg, ans_csr and ans_scan.
//
// Usage: bytes of an Annex B buffer enter on the req_ channel, one per transaction,
// with buffer_end on the final byte and the buffer's timestamp. Each NAL unit found
// between start codes (00 00 01 or 00 00 00 01), and the tail at the buffer end,
// leaves as one descriptor on the rsp_ channel. Bytes before the first start code
// are dropped; a buffer with no start code is one unit.
// Path: the byte that closes a unit waits in the input register, and the descriptor
// computed from it is captured in the result register when that register frees up.
// Throughput: one byte per cycle unless a waiting descriptor is stalled; the scanner
// state is updated from the input register as each byte is accepted, so bytes
// stream back to back. Stall: while rsp_stall holds a waiting descriptor, the input
// register still takes one more byte, then req_stall rises until the descriptor is
// taken. Reset: clears codec_mode to no codec and all buffer state; no clearing pass.
// The user must see that codec_mode is written through the csr_ port only while no
// byte is in flight; the block itself does not enforce this.
`default_nettype none

module annexb_nal_splitter
   import ans_pkg::*;
#(
   parameter int MAX_BUFFER_BYTES = ANS_DEF_MAX_BUFFER_BYTES
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire ans_req_type           req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output ans_rsp_type                rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [ANS_ADDR_W-1:0] csr_paddr,
   input  wire logic [ANS_DATA_W-1:0] csr_pwdata,
   output logic      [ANS_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic        in_valid_ff, in_valid_in;
   ans_req_type in_item_ff,  in_item_in;
   logic        rsp_valid_ff, rsp_valid_in;
   ans_rsp_type rsp_data_ff,  rsp_data_in;
   logic        advance;
   logic        fire;
   logic        emit;
   ans_rsp_type desc;
   logic [1:0]  codec_mode;

   ans_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .codec_mode  (codec_mode)
   );

   ans_scan #(
      .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (in_item_ff),
      .codec_mode (codec_mode),
      .emit       (emit),
      .desc       (desc)
   );

   // The result register frees up when empty or when its transaction is taken.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_item_in = req_data;
         end
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = fire && emit;
         if (fire && emit) begin
            rsp_data_in = desc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule : annexb_nal_splitter

`default_nettype wire

/* tb/tb_annexb_nal_splitter.sv */
// Self-checking testbench for annexb_nal_splitter: streams Annex B byte buffers through the
// req_ channel, predicts every NAL descriptor and checks the rsp_ channel field by field.
// Depends on ans_pkg and the annexb_nal_splitter design.
`timescale 1ns / 100ps

module tb_annexb_nal_splitter;
   import ans_pkg::*;

   localparam int MAX_BYTES      = ANS_DEF_MAX_BUFFER_BYTES;
   localparam int RESET_CYCLES   = 11;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int HOLD_AFTER     = 100;
   localparam int PHASE_ITEMS    = 265;

   // The fourth codec code selects no codec, like ANS_CODEC_NONE.
   localparam logic [1:0] CODEC_SPARE = 2'd3;
   localparam logic [ANS_ADDR_W-1:0] CODEC_ADDR = ANS_ADDR_W'(4 * ANS_REG_CODEC_MODE);

   typedef logic [7:0] byte_queue_type[$];

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   ans_req_type           req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   ans_rsp_type           rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [ANS_ADDR_W-1:0] csr_paddr   = '0;
   logic [ANS_DATA_W-1:0] csr_pwdata  = '0;
   logic [ANS_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Byte transactions waiting to be sent and descriptors waiting to arrive.
   ans_req_type byte_pending[$];
   ans_rsp_type nal_expected[$];

   int mismatches   = 0;
   int items_queued = 0;
   int nal_received = 0;
   int quiet_cycles = 0;
   int send_gap     = 0;
   int send_calm    = 0;
   int recv_pause   = 0;
   int recv_calm    = 0;
   int hold_left    = 0;
   bit held_once    = 1'b0;

   // Shadow of the splitter's buffer scan state and codec selection.
   logic [1:0] codec_sel;
   int         scan_pos;
   int         nal_start;
   logic [2:0] zero_hist;
   logic       start_found;
   logic [7:0] hdr_byte;
   logic       ovf_seen;

   annexb_nal_splitter #(
      .MAX_BUFFER_BYTES(MAX_BYTES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("descriptor %0d %s: got %0h, expected %0h",
                                   nal_received, name, got, want));
   endtask

   // Pause length: mostly none or short, sometimes long, with calm stretches of none.
   function automatic int next_pause(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void clear_scan();
      scan_pos    = 0;
      nal_start   = 0;
      zero_hist   = '0;
      start_found = 1'b0;
      hdr_byte    = '0;
      ovf_seen    = 1'b0;
   endfunction

   // Build one descriptor; the header flags follow the selected codec's NAL type rules.
   function automatic ans_rsp_type make_desc(input int offset, input int length,
                                             input logic is_last, input logic [63:0] stamp);
      ans_rsp_type d;
      logic [4:0]  avc;
      logic [5:0]  hevc;
      d    = '0;
      avc  = hdr_byte[4:0];
      hevc = hdr_byte[6:1];
      if (codec_sel == ANS_CODEC_H264) begin
         d.idr_flag = (avc == ANS_AVC_IDR);
         d.sps_flag = (avc == ANS_AVC_SPS);
         d.pps_flag = (avc == ANS_AVC_PPS);
      end else if (codec_sel == ANS_CODEC_H265 && length >= 2) begin
         d.idr_flag = (hevc == ANS_HEVC_IDR_RADL) || (hevc == ANS_HEVC_IDR_NLP);
         d.vps_flag = (hevc == ANS_HEVC_VPS);
         d.sps_flag = (hevc == ANS_HEVC_SPS);
         d.pps_flag = (hevc == ANS_HEVC_PPS);
      end
      d.nal_offset      = ANS_OFFSET_W'(offset);
      d.nal_length      = ANS_LENGTH_W'(length);
      d.final_of_buffer = is_last;
      d.stamp_out       = stamp;
      d.overflow        = ovf_seen;
      return d;
   endfunction

   // Advance the scan by one byte; returns 1 when the byte closes a NAL unit.
   function automatic bit scan_byte(input ans_req_type item, output ans_rsp_type desc);
      int idx;
      int nxt;
      int sc_len;
      int sc_start;
      int begin_pos;
      bit hit;
      hit  = 1'b0;
      desc = '0;
      idx  = scan_pos;
      // Positions saturate at the buffer limit and mark the buffer as oversized.
      if (idx >= MAX_BYTES) begin
         idx      = MAX_BYTES;
         ovf_seen = 1'b1;
      end
      nxt = (idx + 1 > MAX_BYTES) ? MAX_BYTES : idx + 1;
      if (idx == nal_start) hdr_byte = item.data_byte;

      if (item.data_byte == 8'h01 && zero_hist[1:0] == 2'b11) begin
         // Start code: the longer form when three zeros precede the one.
         sc_len   = zero_hist[2] ? 4 : 3;
         sc_start = (idx + 1 >= sc_len) ? idx + 1 - sc_len : 0;
         if (start_found && sc_start > nal_start) begin
            desc = make_desc(nal_start, sc_start - nal_start, item.buffer_end,
                             item.time_stamp);
            hit  = 1'b1;
         end
         nal_start   = nxt;
         start_found = 1'b1;
         hdr_byte    = '0;
      end else if (item.buffer_end) begin
         // Tail of the buffer, or the whole buffer when no start code was seen.
         begin_pos = start_found ? nal_start : 0;
         if (nxt > begin_pos) begin
            desc = make_desc(begin_pos, nxt - begin_pos, 1'b1, item.time_stamp);
            hit  = 1'b1;
         end
      end

      zero_hist = {zero_hist[1:0], item.data_byte == 8'h00};
      scan_pos  = nxt;
      if (item.buffer_end) clear_scan();
      return hit;
   endfunction

   // Driver: offers queued byte transactions and predicts each one that is accepted.
   always @(posedge clock) begin
      ans_rsp_type desc;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            if (scan_byte(req_data, desc)) nal_expected = {nal_expected, desc};
         end
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (byte_pending.size() != 0) begin
            req_data  <= byte_pending.pop_front();
            req_valid <= 1'b1;
            send_gap = next_pause(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each accepted descriptor and drives random back-pressure,
   // including one long hold-off that lets the splitter fill up.
   always @(posedge clock) begin
      ans_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (nal_expected.size() == 0) begin
               report_mismatch($sformatf("unexpected descriptor, offset %0h length %0h",
                                         rsp_data.nal_offset, rsp_data.nal_length));
            end else begin
               want = nal_expected.pop_front();
               check_field("nal_offset", 64'(rsp_data.nal_offset), 64'(want.nal_offset));
               check_field("nal_length", 64'(rsp_data.nal_length), 64'(want.nal_length));
               check_field("idr_flag", 64'(rsp_data.idr_flag), 64'(want.idr_flag));
               check_field("vps_flag", 64'(rsp_data.vps_flag), 64'(want.vps_flag));
               check_field("sps_flag", 64'(rsp_data.sps_flag), 64'(want.sps_flag));
               check_field("pps_flag", 64'(rsp_data.pps_flag), 64'(want.pps_flag));
               check_field("final_of_buffer", 64'(rsp_data.final_of_buffer),
                           64'(want.final_of_buffer));
               check_field("stamp_out", rsp_data.stamp_out, want.stamp_out);
               check_field("overflow", 64'(rsp_data.overflow), 64'(want.overflow));
            end
            nal_received++;
         end
         if (!held_once && nal_received >= HOLD_AFTER) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (recv_pause > 0) begin
            recv_pause--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            recv_pause = next_pause(recv_calm);
         end
      end
   end

   // Watchdog: ends the run when no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Write codec_mode over the APB port, then read it back.
   task automatic write_codec(input logic [1:0] mode);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CODEC_ADDR;
      csr_pwdata  <= ANS_DATA_W'(mode);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      codec_sel = mode;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("codec_mode readback", 64'(csr_prdata), 64'(mode));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Queue one buffer; from change_at on, the timestamp is inverted.
   task automatic push_buffer(input byte_queue_type bytes, input logic [63:0] stamp,
                              input int change_at);
      ans_req_type item;
      foreach (bytes[i]) begin
         item.data_byte  = bytes[i];
         item.buffer_end = (i == bytes.size() - 1);
         item.time_stamp = (change_at >= 0 && i >= change_at) ? ~stamp : stamp;
         byte_pending = {byte_pending, item};
      end
      items_queued += bytes.size();
   endtask

   // Bytes rich in zeros and ones, so that partial and accidental start codes occur.
   function automatic logic [7:0] noise_byte();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return 8'h00;
      if (roll < 50) return 8'h01;
      return 8'($urandom);
   endfunction

   // NAL header byte, often carrying one of the H.264 or H.265 types that set a flag.
   function automatic logic [7:0] header_byte();
      logic [7:0] raw;
      raw = 8'($urandom);
      case ($urandom_range(0, 11))
         0: raw[4:0] = ANS_AVC_IDR;
         1: raw[4:0] = ANS_AVC_SPS;
         2: raw[4:0] = ANS_AVC_PPS;
         3: raw[6:1] = ANS_HEVC_IDR_RADL;
         4: raw[6:1] = ANS_HEVC_IDR_NLP;
         5: raw[6:1] = ANS_HEVC_VPS;
         6: raw[6:1] = ANS_HEVC_SPS;
         7: raw[6:1] = ANS_HEVC_PPS;
         default: ;
      endcase
      return raw;
   endfunction

   // Random buffer: mostly well-formed start codes and units, some noise and truncation.
   task automatic push_random_buffer();
      byte_queue_type bytes;
      logic [63:0]    stamp;
      int             style;
      int             fill;
      stamp = {$urandom, $urandom};
      style = $urandom_range(0, 99);
      if (style < 12) begin
         repeat ($urandom_range(1, 20)) bytes = {bytes, noise_byte()};
      end else begin
         if (style < 25) repeat ($urandom_range(1, 4)) bytes = {bytes, noise_byte()};
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 2) == 0) bytes = {bytes, 8'h00};
            bytes = {bytes, 8'h00, 8'h00, 8'h01};
            // Now and then leave the unit empty.
            if ($urandom_range(0, 9) != 0) begin
               bytes = {bytes, header_byte()};
               fill = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 120)
                                                   : $urandom_range(0, 6);
               repeat (fill) bytes = {bytes, noise_byte()};
            end
         end
         // Broken sequence: cut the buffer short.
         if (style >= 90) repeat ($urandom_range(1, bytes.size() - 1)) void'(bytes.pop_back());
      end
      push_buffer(bytes, stamp, ($urandom_range(0, 19) == 0) ?
                  $urandom_range(0, bytes.size() - 1) : -1);
   endtask

   // Wait until every transaction is sent and answered, then let the pipeline settle.
   task automatic wait_idle();
      do @(posedge clock);
      while (byte_pending.size() != 0 || req_valid || nal_expected.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Stimulus sequence: directed buffers, then random phases per codec.
   initial begin
      byte_queue_type bytes;
      logic [1:0]     phase_codec;
      int             target;
      clear_scan();
      codec_sel = ANS_CODEC_NONE;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // H.264: long start code, IDR, SPS and PPS units, timestamp change on the last byte.
      write_codec(ANS_CODEC_H264);
      bytes = {8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00, 8'h01, 8'h67,
               8'h00, 8'h00, 8'h01, 8'h68};
      push_buffer(bytes, 64'h0, 12);
      // No start code at all; it ends in a zero that must not carry into the next buffer.
      bytes = {8'hFF, 8'h00};
      push_buffer(bytes, '1, -1);
      // Start code on the last byte: the previous unit is final, the empty tail is not sent.
      bytes = {8'h00, 8'h00, 8'h01, 8'h41, 8'h00, 8'h00, 8'h01};
      push_buffer(bytes, {$urandom, $urandom}, -1);
      wait_idle();

      // H.265: a two-byte VPS, then a one-byte unit whose type would be IDR.
      write_codec(ANS_CODEC_H265);
      bytes = {8'h00, 8'h00, 8'h01, 8'h40, 8'h01, 8'h00, 8'h00, 8'h01, 8'h26};
      push_buffer(bytes, {$urandom, $urandom}, -1);
      wait_idle();

      // Random phases over every codec setting.
      for (int p = 0; p < 5; p++) begin
         case (p)
            0:       phase_codec = ANS_CODEC_H265;
            1:       phase_codec = ANS_CODEC_NONE;
            2:       phase_codec = CODEC_SPARE;
            3:       phase_codec = ANS_CODEC_H264;
            default: phase_codec = ANS_CODEC_H265;
         endcase
         write_codec(phase_codec);
         target = items_queued + PHASE_ITEMS;
         while (items_queued < target) push_random_buffer();
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
